// File: rtl/core/psg_adsr_envelope_driver_defines.svh
// Assertion macros used by the checker file of the envelope driver.
`ifndef PSG_ADSR_ENVELOPE_DRIVER_DEFINES_SVH
`define PSG_ADSR_ENVELOPE_DRIVER_DEFINES_SVH

// Checked outside reset.
`define PSG_ASSERT(lbl, prop, msg) \
   lbl: assert property (@(posedge clock) disable iff (reset) prop) else $error(msg);

// Checked in every cycle, reset included.
`define PSG_ASSERT_ALWAYS(lbl, prop, msg) \
   lbl: assert property (@(posedge clock) prop) else $error(msg);

`endif

// File: rtl/core/psg_pkg.sv
// Package: types, tables and constants of the PSG ADSR envelope driver.
package psg_pkg;

   localparam int CHANNELS            = 4;
   localparam int CH_W                = $clog2(CHANNELS);
   localparam int NOTE_TABLE_SIZE     = 96;
   localparam int INSTRUMENTS_DEFAULT = 24;
   localparam int ROM_SIZE            = 32;
   localparam int BUF_BYTES           = 8;

   localparam logic [7:0] LATCH_BIT    = 8'h80;
   localparam logic [3:0] ATTEN_OFF    = 4'd15;
   localparam logic [7:0] NOTE_BIAS    = 8'd12;
   localparam logic [7:0] DUAL_OFFSET  = 8'd76;
   localparam logic [4:0] INST_DUAL    = 5'd10;
   localparam logic [2:0] REG_NOISE    = 3'd6;
   localparam logic [2:0] REG_TONE_C   = 3'd4;
   localparam logic [1:0] CH_NOISE     = 2'd3;
   localparam logic [1:0] CH_TONE_C    = 2'd2;

   typedef enum logic [2:0] {
      OP_NOTE_ON     = 3'd0,
      OP_NOTE_OFF    = 3'd1,
      OP_INSTRUMENT  = 3'd2,
      OP_TICK        = 3'd3,
      OP_RELEASE_ALL = 3'd4,
      OP_SILENCE     = 3'd5,
      OP_RESET       = 3'd6
   } op_type;

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_READ,
      ST_EXEC,
      ST_DRAIN,
      ST_FLUSH
   } state_type;

   typedef struct packed {
      op_type      operation;
      logic [1:0]  channel;
      logic [7:0]  hw_channel;
      logic [7:0]  value;
   } req_type;

   typedef struct packed {
      logic [7:0]  port_byte;
      logic        byte_valid;
      logic [1:0]  channel_out;
      logic        last;
   } rsp_type;

   typedef struct packed {
      logic [4:0]  inst;
      logic [7:0]  shift;
      logic        key;
      logic        peak;
      logic [3:0]  peak_lvl;
      logic [8:0]  steps;
      logic [8:0]  periods;
      logic [3:0]  sus;
      logic [2:0]  tick;
      logic [3:0]  level;
   } ch_state_type;

   typedef struct packed {
      logic                rd_en;
      logic                wr_en;
      logic [CH_W-1:0]     addr;
      ch_state_type        wr_data;
   } mem_req_type;

   typedef struct packed {
      logic [3:0]  amp;
      logic [2:0]  atk;
      logic [2:0]  dec;
      logic [3:0]  sus;
      logic [2:0]  rel;
      logic [7:0]  tp;
      logic        noise;
      logic [2:0]  nflags;
   } instr_type;

   localparam logic [9:0] PERIOD_ROM [NOTE_TABLE_SIZE] = '{
      10'h0,10'h0,10'h0,10'h0,10'h0,10'h0, 10'h0,10'h0,10'h0,10'h0,10'h0,10'h0,
      10'h0,10'h0,10'h0,10'h0,10'h0,10'h0, 10'h0,10'h0,10'h0,10'h0,10'h0,10'h0,
      10'h0,10'h0,10'h0,10'h0,10'h0,10'h0, 10'h0,10'h0,10'h0,10'h3f9,10'h3c0,10'h38a,
      10'h357,10'h327,10'h2fa,10'h2cf,10'h2a7,10'h281,
      10'h25d,10'h23b,10'h21b,10'h1fc,10'h1e0,10'h1c5,
      10'h1ac,10'h194,10'h17d,10'h168,10'h153,10'h140,
      10'h12e,10'h11d,10'h10d,10'h0fe,10'h0f0,10'h0e2,
      10'h0d6,10'h0ca,10'h0be,10'h0b4,10'h0aa,10'h0a0,
      10'h097,10'h08f,10'h087,10'h07f,10'h078,10'h071,
      10'h06b,10'h065,10'h05f,10'h05a,10'h055,10'h050,
      10'h04c,10'h047,10'h043,10'h040,10'h03c,10'h039,
      10'h035,10'h032,10'h030,10'h02d,10'h02a,10'h028,
      10'h026,10'h024,10'h022,10'h020,10'h01e,10'h01c
   };

   localparam logic [3:0] ATTEN_ROM [16] = '{
      4'd15, 4'd12, 4'd9, 4'd7, 4'd6, 4'd5, 4'd4, 4'd3,
      4'd3, 4'd2, 4'd2, 4'd1, 4'd1, 4'd1, 4'd0, 4'd0
   };

   function automatic instr_type instr_rom(input logic [4:0] idx);
      instr_type r;
      case (idx)
         5'd0:  r = '{4'hD,3'd0,3'd4,4'h0,3'd2,8'd0,  1'b0,3'd0};
         5'd1:  r = '{4'hA,3'd0,3'd0,4'hA,3'd6,8'd0,  1'b0,3'd0};
         5'd2:  r = '{4'hD,3'd0,3'd4,4'h0,3'd2,8'd0,  1'b0,3'd0};
         5'd3:  r = '{4'hE,3'd0,3'd3,4'h0,3'd3,8'd12, 1'b1,3'd4};
         5'd4:  r = '{4'hF,3'd0,3'd3,4'h0,3'd2,8'd12, 1'b0,3'd0};
         5'd5:  r = '{4'h8,3'd0,3'd0,4'h8,3'd6,8'd0,  1'b0,3'd0};
         5'd6:  r = '{4'hF,3'd0,3'd6,4'h0,3'd6,8'd244,1'b0,3'd0};
         5'd7:  r = '{4'h6,3'd0,3'd3,4'h0,3'd0,8'd0,  1'b1,3'd4};
         5'd8:  r = '{4'hC,3'd0,3'd4,4'h0,3'd0,8'd0,  1'b1,3'd5};
         5'd9:  r = '{4'hC,3'd0,3'd4,4'h4,3'd4,8'd0,  1'b1,3'd6};
         5'd10: r = '{4'hB,3'd2,3'd5,4'h0,3'd5,8'd0,  1'b1,3'd7};
         5'd11: r = '{4'h7,3'd0,3'd1,4'h5,3'd1,8'd0,  1'b1,3'd4};
         5'd12: r = '{4'hB,3'd4,3'd5,4'h0,3'd5,8'd0,  1'b1,3'd4};
         5'd13: r = '{4'hF,3'd0,3'd2,4'h0,3'd2,8'd0,  1'b1,3'd1};
         5'd14: r = '{4'hC,3'd0,3'd1,4'h0,3'd0,8'd32, 1'b0,3'd0};
         5'd15: r = '{4'hD,3'd0,3'd4,4'h0,3'd4,8'd43, 1'b0,3'd0};
         5'd16: r = '{4'hF,3'd1,3'd2,4'h0,3'd2,8'd44, 1'b0,3'd0};
         5'd17: r = '{4'hA,3'd0,3'd4,4'h0,3'd0,8'd0,  1'b1,3'd5};
         5'd18: r = '{4'hF,3'd0,3'd4,4'hF,3'd4,8'd0,  1'b1,3'd6};
         5'd19: r = '{4'hF,3'd3,3'd4,4'h8,3'd1,8'd0,  1'b0,3'd0};
         5'd20: r = '{4'h8,3'd0,3'd2,4'h0,3'd2,8'd0,  1'b0,3'd0};
         5'd21: r = '{4'hB,3'd0,3'd3,4'h0,3'd0,8'd0,  1'b1,3'd0};
         5'd22: r = '{4'h9,3'd0,3'd2,4'h0,3'd0,8'd72, 1'b0,3'd0};
         5'd23: r = '{4'hB,3'd0,3'd3,4'h0,3'd0,8'd0,  1'b1,3'd0};
         default: r = '0;
      endcase
      return r;
   endfunction

endpackage

// File: rtl/core/psg_chmem.sv
// Per-channel state memory: one write and one registered read per cycle.
module psg_chmem (
   input  logic                   clock,
   input  logic                   reset,
   input  psg_pkg::mem_req_type   mem_req,
   output psg_pkg::ch_state_type  rd_data
);

   psg_pkg::ch_state_type           mem [psg_pkg::CHANNELS];
   logic [psg_pkg::CHANNELS-1:0]    valid_ff;
   logic [psg_pkg::CHANNELS-1:0]    valid_in;
   psg_pkg::ch_state_type           data_ff;
   logic                            hit_ff;

   always_ff @(posedge clock) begin
      if (mem_req.wr_en) begin
         mem[mem_req.addr] <= mem_req.wr_data;
      end
      if (mem_req.rd_en) begin
         data_ff <= mem[mem_req.addr];
      end
   end

   always_comb begin
      valid_in = valid_ff;
      if (mem_req.wr_en) begin
         valid_in[mem_req.addr] = 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= '0;
         hit_ff   <= 1'b0;
      end else begin
         valid_ff <= valid_in;
         if (mem_req.rd_en) begin
            hit_ff <= valid_ff[mem_req.addr];
         end
      end
   end

   assign rd_data = hit_ff ? data_ff : '0;

endmodule

// File: rtl/core/psg_seq.sv
// Command sequencer: channel read-modify-write, byte generation and result output.
module psg_seq #(
   parameter int INSTRUMENT_COUNT = psg_pkg::INSTRUMENTS_DEFAULT
) (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   start,
   output logic                   busy,
   input  psg_pkg::req_type       req_item,
   output logic                   rsp_strobe,
   output psg_pkg::rsp_type       rsp_item,
   output psg_pkg::mem_req_type   mem_req,
   input  psg_pkg::ch_state_type  rd_data
);

   typedef struct packed {
      logic [3:0]  count;
      logic [psg_pkg::BUF_BYTES*8-1:0] data;
   } bytes_type;

   function automatic bytes_type push(input bytes_type acc, input logic [7:0] b);
      bytes_type r;
      r = acc;
      r.data[{acc.count[2:0], 3'b000} +: 8] = b;
      r.count = acc.count + 4'd1;
      return r;
   endfunction

   function automatic logic [7:0] nib(input logic [2:0] reg_no, input logic [3:0] v);
      return psg_pkg::LATCH_BIT | {1'b0, reg_no, v};
   endfunction

   function automatic bytes_type put_word(input bytes_type acc, input logic [2:0] reg_no,
                                          input logic [9:0] v);
      bytes_type r;
      r = push(acc, nib(reg_no, v[3:0]));
      r = push(r, {2'b00, v[9:4]});
      return r;
   endfunction

   function automatic bytes_type play_note(input bytes_type acc, input logic [1:0] c,
                                           input logic [7:0] note);
      logic [7:0] idx;
      logic [9:0] tone;
      bytes_type  r;
      idx  = note + psg_pkg::NOTE_BIAS;
      tone = (idx < 8'(psg_pkg::NOTE_TABLE_SIZE)) ? psg_pkg::PERIOD_ROM[idx[6:0]] : '0;
      r = push(acc, nib({c, 1'b1}, psg_pkg::ATTEN_ROM[0]));
      r = put_word(r, {c, 1'b0}, tone);
      return r;
   endfunction

   function automatic bytes_type stop_tone(input bytes_type acc, input logic [1:0] c,
                                           input logic [4:0] inst);
      bytes_type r;
      r = acc;
      if (c != psg_pkg::CH_NOISE) begin
         r = put_word(r, {c, 1'b0}, '0);
      end
      if (inst == psg_pkg::INST_DUAL) begin
         r = put_word(r, psg_pkg::REG_TONE_C, '0);
      end
      return r;
   endfunction

   function automatic logic [1:0] mod3(input logic [7:0] v);
      logic [3:0] s;
      logic [2:0] r;
      s = 4'(v[1:0]) + 4'(v[3:2]) + 4'(v[5:4]) + 4'(v[7:6]);
      r = 3'(s[1:0]) + 3'(s[3:2]);
      if (r >= 3'd3) r = r - 3'd3;
      if (r >= 3'd3) r = r - 3'd3;
      return r[1:0];
   endfunction

   function automatic void load_stage(inout logic [8:0] steps, inout logic [8:0] periods,
                                      input int stage, input logic [2:0] v);
      if (v == 3'd0) begin
         periods[stage*3 +: 3] = 3'd0;
      end else begin
         steps[stage*3 +: 3]   = (v < 3'd4) ? 3'd5 - v : 3'd1;
         periods[stage*3 +: 3] = (v > 3'd4) ? v - 3'd3 : 3'd1;
      end
   endfunction

   psg_pkg::state_type     state_ff, state_in;
   psg_pkg::op_type        op_ff, op_in;
   logic [1:0]             ch_ff, ch_in;
   logic [1:0]             chout_ff, chout_in;
   logic [7:0]             x_ff, x_in;
   logic [1:0]             idx_ff, idx_in;
   logic                   pass_ff, pass_in;
   logic                   more_ff, more_in;
   logic [psg_pkg::BUF_BYTES*8-1:0] buf_ff, buf_in;
   logic [3:0]             cnt_ff, cnt_in;
   logic [2:0]             pos_ff, pos_in;
   logic                   hold_vld_ff, hold_vld_in;
   logic [7:0]             hold_ff, hold_in;
   logic                   rsp_strobe_ff, rsp_strobe_in;
   psg_pkg::rsp_type       rsp_ff, rsp_in;

   logic                   x_ok;
   logic                   req_x_ok;
   psg_pkg::instr_type     req_ins;
   psg_pkg::instr_type     ins;
   logic [1:0]             cur_addr;
   bytes_type              ex_bytes;
   psg_pkg::ch_state_type  ex_state;
   logic                   ex_wr;
   logic                   ex_more;
   logic                   drain_end;

   assign x_ok     = x_ff < 8'(INSTRUMENT_COUNT);
   assign req_x_ok = req_item.value < 8'(INSTRUMENT_COUNT);
   assign req_ins  = psg_pkg::instr_rom(req_item.value[4:0]);
   assign ins      = psg_pkg::instr_rom(x_ff[4:0]);
   assign drain_end = ({1'b0, pos_ff} == cnt_ff - 4'd1);

   always_comb begin
      cur_addr = ch_ff;
      if (op_ff == psg_pkg::OP_TICK || op_ff == psg_pkg::OP_RELEASE_ALL) begin
         cur_addr = idx_ff;
      end else if (op_ff == psg_pkg::OP_INSTRUMENT && pass_ff) begin
         cur_addr = chout_ff;
      end
   end

   // execute step on the channel entry just read
   always_comb begin
      logic [4:0] a;
      logic [2:0] t;
      logic       pr;
      logic [2:0] p;
      logic [2:0] s;
      logic [3:0] old;
      ex_bytes = '0;
      ex_state = rd_data;
      ex_wr    = 1'b0;
      ex_more  = 1'b0;
      a   = {1'b0, rd_data.level};
      t   = rd_data.tick;
      pr  = rd_data.peak;
      old = rd_data.level;
      p   = '0;
      s   = '0;
      case (op_ff)
         psg_pkg::OP_NOTE_ON: begin
            if (ch_ff != psg_pkg::CH_NOISE) begin
               ex_bytes = play_note(ex_bytes, ch_ff, x_ff + rd_data.shift);
            end
            if (rd_data.inst == psg_pkg::INST_DUAL) begin
               ex_bytes = play_note(ex_bytes, psg_pkg::CH_TONE_C, x_ff + psg_pkg::DUAL_OFFSET);
            end
            ex_state.key  = 1'b1;
            ex_state.peak = 1'b0;
            ex_state.tick = '0;
            ex_wr = 1'b1;
         end
         psg_pkg::OP_NOTE_OFF: begin
            ex_state.key = 1'b0;
            ex_wr = 1'b1;
         end
         psg_pkg::OP_RELEASE_ALL: begin
            ex_state.key = 1'b0;
            ex_wr   = 1'b1;
            ex_more = (idx_ff != 2'(psg_pkg::CHANNELS - 1));
         end
         psg_pkg::OP_INSTRUMENT: begin
            if (x_ok && !pass_ff) begin
               ex_bytes = stop_tone(ex_bytes, ch_ff, rd_data.inst);
               if (ins.noise) begin
                  ex_bytes = push(ex_bytes, nib(psg_pkg::REG_NOISE, {1'b0, ins.nflags}));
               end
               ex_more = 1'b1;
            end else if (x_ok) begin
               ex_state.inst     = x_ff[4:0];
               ex_state.peak_lvl = ins.amp;
               ex_state.shift    = ins.tp;
               ex_state.tick     = '0;
               load_stage(ex_state.steps, ex_state.periods, 0, ins.atk);
               load_stage(ex_state.steps, ex_state.periods, 1, ins.dec);
               load_stage(ex_state.steps, ex_state.periods, 2, ins.rel);
               ex_state.sus = (ins.sus == '0 && ins.dec == '0) ? ins.amp : ins.sus;
               ex_state.key   = 1'b0;
               ex_state.level = '0;
               ex_wr = 1'b1;
            end
         end
         psg_pkg::OP_TICK: begin
            if (rd_data.key) begin
               if (!pr) begin
                  p = rd_data.periods[2:0];
                  if (p == '0) begin
                     pr = 1'b1;
                     a  = {1'b0, rd_data.peak_lvl};
                  end else begin
                     t = t + 3'd1;
                     if (t >= p) begin
                        a = a + {2'b00, rd_data.steps[2:0]};
                        if (a >= {1'b0, rd_data.peak_lvl}) begin
                           a  = {1'b0, rd_data.peak_lvl};
                           pr = 1'b1;
                        end
                        t = '0;
                     end
                  end
               end
               if (pr) begin
                  p = rd_data.periods[5:3];
                  s = rd_data.steps[5:3];
                  if (p == '0) begin
                     a = {1'b0, rd_data.sus};
                  end else if (a > {1'b0, rd_data.sus}) begin
                     t = t + 3'd1;
                     if (t >= p) begin
                        a = (a < {2'b00, s}) ? '0 : a - {2'b00, s};
                        if (a < {1'b0, rd_data.sus}) a = {1'b0, rd_data.sus};
                        t = '0;
                     end
                  end
               end
            end else if (a != '0) begin
               p = rd_data.periods[8:6];
               s = rd_data.steps[8:6];
               if (p == '0) begin
                  a = '0;
               end else begin
                  t = t + 3'd1;
                  if (t >= p) begin
                     a = (a < {2'b00, s}) ? '0 : a - {2'b00, s};
                     t = '0;
                  end
               end
            end
            if (a[3:0] != old) begin
               ex_bytes = push(ex_bytes, nib({idx_ff, 1'b1}, psg_pkg::ATTEN_ROM[a[3:0]]));
               if (a[3:0] != '0 && old == '0) begin
                  t = '0;
               end else if (a[3:0] == '0 && old != '0) begin
                  ex_bytes = stop_tone(ex_bytes, idx_ff, rd_data.inst);
                  t = '0;
               end
            end
            ex_state.level = a[3:0];
            ex_state.peak  = pr;
            ex_state.tick  = t;
            ex_wr   = 1'b1;
            ex_more = (idx_ff != 2'(psg_pkg::CHANNELS - 1));
         end
         psg_pkg::OP_SILENCE: begin
            for (int i = 0; i < psg_pkg::CHANNELS; i++) begin
               ex_bytes = push(ex_bytes, nib({2'(i), 1'b1}, psg_pkg::ATTEN_OFF));
            end
         end
         psg_pkg::OP_RESET: begin
            for (int i = 0; i < psg_pkg::CHANNELS; i++) begin
               ex_bytes = push(ex_bytes, nib({2'(i), 1'b0}, '0));
               ex_bytes = push(ex_bytes, nib({2'(i), 1'b1}, psg_pkg::ATTEN_OFF));
            end
         end
         default: begin
         end
      endcase
   end

   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         psg_pkg::ST_IDLE:  if (start) state_in = psg_pkg::ST_READ;
         psg_pkg::ST_READ:  state_in = psg_pkg::ST_EXEC;
         psg_pkg::ST_EXEC: begin
            if (ex_bytes.count != '0) state_in = psg_pkg::ST_DRAIN;
            else if (ex_more)         state_in = psg_pkg::ST_READ;
            else                      state_in = psg_pkg::ST_FLUSH;
         end
         psg_pkg::ST_DRAIN: begin
            if (drain_end) state_in = more_ff ? psg_pkg::ST_READ : psg_pkg::ST_FLUSH;
         end
         psg_pkg::ST_FLUSH: state_in = psg_pkg::ST_IDLE;
         default:           state_in = psg_pkg::ST_IDLE;
      endcase
   end

   always_comb begin
      op_in         = op_ff;
      ch_in         = ch_ff;
      chout_in      = chout_ff;
      x_in          = x_ff;
      idx_in        = idx_ff;
      pass_in       = pass_ff;
      more_in       = more_ff;
      buf_in        = buf_ff;
      cnt_in        = cnt_ff;
      pos_in        = pos_ff;
      hold_vld_in   = hold_vld_ff;
      hold_in       = hold_ff;
      rsp_strobe_in = 1'b0;
      rsp_in        = rsp_ff;
      mem_req         = '0;
      mem_req.addr    = cur_addr;
      mem_req.wr_data = ex_state;
      unique case (state_ff)
         psg_pkg::ST_IDLE: begin
            if (start) begin
               op_in       = req_item.operation;
               ch_in       = req_item.channel;
               x_in        = req_item.value;
               idx_in      = '0;
               pass_in     = 1'b0;
               hold_vld_in = 1'b0;
               chout_in    = req_item.channel;
               if (req_item.operation == psg_pkg::OP_INSTRUMENT && req_x_ok) begin
                  if (req_ins.noise) begin
                     chout_in = psg_pkg::CH_NOISE;
                  end else if (req_item.channel == psg_pkg::CH_NOISE) begin
                     chout_in = mod3(req_item.hw_channel);
                  end
               end
            end
         end
         psg_pkg::ST_READ: begin
            mem_req.rd_en = 1'b1;
         end
         psg_pkg::ST_EXEC: begin
            mem_req.wr_en = ex_wr;
            buf_in  = ex_bytes.data;
            cnt_in  = ex_bytes.count;
            pos_in  = '0;
            more_in = ex_more;
            if (ex_more) begin
               idx_in  = idx_ff + 2'd1;
               pass_in = 1'b1;
            end
         end
         psg_pkg::ST_DRAIN: begin
            rsp_strobe_in = hold_vld_ff;
            rsp_in        = '{hold_ff, 1'b1, chout_ff, 1'b0};
            hold_in       = buf_ff[{pos_ff, 3'b000} +: 8];
            hold_vld_in   = 1'b1;
            pos_in        = pos_ff + 3'd1;
         end
         psg_pkg::ST_FLUSH: begin
            rsp_strobe_in = 1'b1;
            rsp_in        = '{hold_vld_ff ? hold_ff : '0, hold_vld_ff, chout_ff, 1'b1};
            hold_vld_in   = 1'b0;
         end
         default: begin
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff      <= psg_pkg::ST_IDLE;
         rsp_strobe_ff <= 1'b0;
         hold_vld_ff   <= 1'b0;
         more_ff       <= 1'b0;
         pass_ff       <= 1'b0;
      end else begin
         state_ff      <= state_in;
         rsp_strobe_ff <= rsp_strobe_in;
         hold_vld_ff   <= hold_vld_in;
         more_ff       <= more_in;
         pass_ff       <= pass_in;
      end
   end

   always_ff @(posedge clock) begin
      op_ff    <= op_in;
      ch_ff    <= ch_in;
      chout_ff <= chout_in;
      x_ff     <= x_in;
      idx_ff   <= idx_in;
      buf_ff   <= buf_in;
      cnt_ff   <= cnt_in;
      pos_ff   <= pos_in;
      hold_ff  <= hold_in;
      rsp_ff   <= rsp_in;
   end

   assign busy       = (state_ff != psg_pkg::ST_IDLE);
   assign rsp_strobe = rsp_strobe_ff;
   assign rsp_item   = rsp_ff;

endmodule

// File: rtl/core/psg_adsr_envelope_driver.sv
// Top level of the PSG ADSR envelope driver.
// A command is taken when start is high and busy is low; busy falls in the cycle that
// shows the result carrying last, and a new command may be taken in that cycle. Results
// appear one per cycle for one cycle each, marked by rsp_strobe, and cannot be held off;
// the flow pauses while a channel entry is read and executed and its first byte loaded.
// Each pass over the channel state memory reads the entry, then executes and writes it
// back, and every port byte then goes out as one result; the last result carries last.
module psg_adsr_envelope_driver #(
   parameter int INSTRUMENT_COUNT = psg_pkg::INSTRUMENTS_DEFAULT
) (
   input  logic              clock,
   input  logic              reset,
   input  logic              start,
   output logic              busy,
   input  psg_pkg::req_type  req_item,
   output logic              rsp_strobe,
   output psg_pkg::rsp_type  rsp_item
);

   psg_pkg::mem_req_type   mem_req;
   psg_pkg::ch_state_type  rd_data;

   psg_seq #(
      .INSTRUMENT_COUNT(INSTRUMENT_COUNT)
   ) u_seq (
      .clock      (clock),
      .reset      (reset),
      .start      (start),
      .busy       (busy),
      .req_item   (req_item),
      .rsp_strobe (rsp_strobe),
      .rsp_item   (rsp_item),
      .mem_req    (mem_req),
      .rd_data    (rd_data)
   );

   psg_chmem u_chmem (
      .clock   (clock),
      .reset   (reset),
      .mem_req (mem_req),
      .rd_data (rd_data)
   );

endmodule

// File: rtl/core/psg_checker.sv
// Port-level checker of the PSG ADSR envelope driver, bound to the top level.
`include "psg_adsr_envelope_driver_defines.svh"

module psg_checker (
   input logic              clock,
   input logic              reset,
   input logic              start,
   input logic              busy,
   input logic              rsp_strobe,
   input psg_pkg::rsp_type  rsp_item
);

   `PSG_ASSERT_ALWAYS(a_reset_quiet, reset |=> !busy && !rsp_strobe, "not idle after reset")
   `PSG_ASSERT(a_accept_busy, start && !busy |=> busy, "transaction accepted but not busy")
   `PSG_ASSERT(a_result_in_txn, rsp_strobe |-> $past(busy), "result outside a transaction")
   `PSG_ASSERT(a_last_ends, rsp_strobe && rsp_item.last |-> !busy, "last result but still busy")
   `PSG_ASSERT(a_empty_is_last, rsp_strobe && !rsp_item.byte_valid |-> rsp_item.last,
      "empty result not last")

endmodule

bind psg_adsr_envelope_driver psg_checker u_psg_checker (.*);

// File: tb/psg_adsr_envelope_driver_test.sv
// Testbench for the PSG ADSR envelope driver: command stimulus, predicted port bytes, checks.
module psg_adsr_envelope_driver_test;

   localparam int INST_COUNT = 24;
   localparam int CYCLE_LIMIT = 400000;

   logic             clock;
   logic             reset;
   logic             start;
   logic             busy;
   psg_pkg::req_type req_item;
   logic             rsp_strobe;
   psg_pkg::rsp_type rsp_item;

   psg_adsr_envelope_driver #(.INSTRUMENT_COUNT(INST_COUNT)) u_dut (
      .clock(clock), .reset(reset), .start(start), .busy(busy),
      .req_item(req_item), .rsp_strobe(rsp_strobe), .rsp_item(rsp_item)
   );

   // predictor state per channel
   logic [4:0] m_inst [psg_pkg::CHANNELS];
   logic [7:0] m_shift [psg_pkg::CHANNELS];
   logic       m_key [psg_pkg::CHANNELS];
   logic       m_peak [psg_pkg::CHANNELS];
   logic [3:0] m_peak_lvl [psg_pkg::CHANNELS];
   logic [8:0] m_steps [psg_pkg::CHANNELS];
   logic [8:0] m_periods [psg_pkg::CHANNELS];
   logic [3:0] m_sus [psg_pkg::CHANNELS];
   logic [2:0] m_tick [psg_pkg::CHANNELS];
   logic [3:0] m_level [psg_pkg::CHANNELS];

   logic [7:0]       port_bytes [$];
   psg_pkg::rsp_type expected_rsp [$];
   psg_pkg::req_type pending_cmds [$];
   int               errors = 0;
   int               cycles = 0;
   int               gap;
   bit               hold_until_drained;
   logic             taken;

   initial clock = 1'b0;
   always #5 clock = ~clock;

   function automatic logic [7:0] latch_byte(input logic [2:0] r, input logic [3:0] d);
      return psg_pkg::LATCH_BIT | {1'b0, r, d};
   endfunction

   task automatic put_nib(input logic [2:0] r, input logic [3:0] d);
      port_bytes.push_back(latch_byte(r, d));
   endtask

   task automatic put_word(input logic [2:0] r, input logic [9:0] v);
      put_nib(r, v[3:0]);
      port_bytes.push_back({2'b00, v[9:4]});
   endtask

   task automatic play_note(input logic [1:0] c, input logic [7:0] x);
      logic [7:0] idx;
      logic [9:0] tone;
      idx = x + psg_pkg::NOTE_BIAS;
      tone = (idx < psg_pkg::NOTE_TABLE_SIZE) ? psg_pkg::PERIOD_ROM[idx[6:0]] : 10'd0;
      put_nib({c, 1'b1}, psg_pkg::ATTEN_ROM[0]);
      put_word({c, 1'b0}, tone);
   endtask

   task automatic stop_tone(input int ch);
      if (ch < 3) put_word({ch[1:0], 1'b0}, 10'd0);
      if (m_inst[ch] == psg_pkg::INST_DUAL) put_word(psg_pkg::REG_TONE_C, 10'd0);
   endtask

   task automatic load_stage(input int ch, input int stg, input logic [2:0] v);
      if (v == 0) begin
         m_periods[ch][stg*3 +: 3] = 3'd0;
      end else begin
         m_steps[ch][stg*3 +: 3] = (v < 4) ? 3'(5 - v) : 3'd1;
         m_periods[ch][stg*3 +: 3] = (v > 4) ? 3'(v - 3) : 3'd1;
      end
   endtask

   function automatic bit bump(input int ch, input int p);
      m_tick[ch] = m_tick[ch] + 3'd1;
      return m_tick[ch] >= p;
   endfunction

   task automatic envelope_step(input int ch);
      int old, a, ta, p, s;
      old = m_level[ch];
      a = old;
      if (m_key[ch]) begin
         if (!m_peak[ch]) begin
            p = m_periods[ch][2:0];
            ta = m_peak_lvl[ch];
            if (p == 0) begin
               m_peak[ch] = 1'b1;
               a = ta;
            end else if (bump(ch, p)) begin
               a += m_steps[ch][2:0];
               if (a >= ta) begin
                  a = ta;
                  m_peak[ch] = 1'b1;
               end
               m_tick[ch] = 3'd0;
            end
         end
         if (m_peak[ch]) begin
            p = m_periods[ch][5:3];
            s = m_steps[ch][5:3];
            ta = m_sus[ch];
            if (p == 0) begin
               a = ta;
            end else if (a > ta && bump(ch, p)) begin
               a = (a < s) ? 0 : a - s;
               if (a < ta) a = ta;
               m_tick[ch] = 3'd0;
            end
         end
      end else begin
         p = m_periods[ch][8:6];
         s = m_steps[ch][8:6];
         if (a == 0) return;
         if (p == 0) begin
            a = 0;
         end else if (bump(ch, p)) begin
            a = (a < s) ? 0 : a - s;
            m_tick[ch] = 3'd0;
         end
      end
      if (a != old) begin
         a &= 15;
         put_nib({ch[1:0], 1'b1}, psg_pkg::ATTEN_ROM[a[3:0]]);
         if (a != 0 && old == 0) begin
            m_tick[ch] = 3'd0;
         end else if (a == 0 && old != 0) begin
            stop_tone(ch);
            m_tick[ch] = 3'd0;
         end
         m_level[ch] = 4'(a);
      end
   endtask

   task automatic pick_instrument(input int ch, input logic [7:0] hw, input logic [7:0] x,
                                  output logic [1:0] ch_out);
      psg_pkg::instr_type in;
      int c;
      c = ch;
      ch_out = 2'(ch);
      if (x >= INST_COUNT) return;
      in = psg_pkg::instr_rom(x[4:0]);
      stop_tone(c);
      if (in.noise) begin
         c = psg_pkg::CH_NOISE;
         put_nib(psg_pkg::REG_NOISE, {1'b0, in.nflags});
      end else if (c >= 3) begin
         c = hw % 3;
      end
      m_inst[c] = x[4:0];
      m_peak_lvl[c] = in.amp;
      m_shift[c] = in.tp;
      m_tick[c] = 3'd0;
      load_stage(c, 0, in.atk);
      load_stage(c, 1, in.dec);
      m_sus[c] = in.sus;
      load_stage(c, 2, in.rel);
      if (in.sus == 0 && in.dec == 0) m_sus[c] = in.amp;
      m_key[c] = 1'b0;
      m_level[c] = 4'd0;
      ch_out = 2'(c);
   endtask

   task automatic predict_command(input psg_pkg::req_type cmd);
      logic [1:0] ch;
      psg_pkg::rsp_type r;
      ch = cmd.channel;
      port_bytes.delete();
      case (cmd.operation)
         psg_pkg::OP_NOTE_ON: begin
            if (ch < 3) play_note(ch, cmd.value + m_shift[ch]);
            if (m_inst[ch] == psg_pkg::INST_DUAL)
               play_note(psg_pkg::CH_TONE_C, cmd.value + psg_pkg::DUAL_OFFSET);
            m_key[ch] = 1'b1;
            m_peak[ch] = 1'b0;
            m_tick[ch] = 3'd0;
         end
         psg_pkg::OP_NOTE_OFF: m_key[ch] = 1'b0;
         psg_pkg::OP_INSTRUMENT: pick_instrument(ch, cmd.hw_channel, cmd.value, ch);
         psg_pkg::OP_TICK: for (int i = 0; i < psg_pkg::CHANNELS; i++) envelope_step(i);
         psg_pkg::OP_RELEASE_ALL: for (int i = 0; i < psg_pkg::CHANNELS; i++) m_key[i] = 1'b0;
         psg_pkg::OP_SILENCE:
            for (int i = 0; i < 8; i += 2) put_nib(3'(i + 1), psg_pkg::ATTEN_OFF);
         psg_pkg::OP_RESET: for (int i = 0; i < 8; i += 2) begin
            put_nib(3'(i), 4'd0);
            put_nib(3'(i + 1), psg_pkg::ATTEN_OFF);
         end
         default: ;
      endcase
      if (port_bytes.size() == 0) begin
         r = '{8'd0, 1'b0, ch, 1'b1};
         expected_rsp.push_back(r);
      end else begin
         for (int k = 0; k < port_bytes.size(); k++) begin
            r = '{port_bytes[k], 1'b1, ch, k == port_bytes.size() - 1};
            expected_rsp.push_back(r);
         end
      end
   endtask

   task automatic report_mismatch(input string what, input int got, input int want);
      errors++;
      $display("mismatch %s: got 0x%0h expected 0x%0h at cycle %0d", what, got, want, cycles);
   endtask

   function automatic int pick_gap();
      int r;
      r = $urandom_range(0, 99);
      if (r < 45) return 0;
      if (r < 92) return $urandom_range(1, 3);
      return $urandom_range(10, 40);
   endfunction

   task automatic queue_cmd(input logic [2:0] op, input logic [1:0] ch,
                            input logic [7:0] hw, input logic [7:0] v);
      psg_pkg::req_type c;
      c.operation = psg_pkg::op_type'(op);
      c.channel = ch;
      c.hw_channel = hw;
      c.value = v;
      pending_cmds.push_back(c);
   endtask

   // acceptance and prediction
   always @(posedge clock) begin
      taken <= !reset && start && !busy;
      if (reset) begin
         for (int i = 0; i < psg_pkg::CHANNELS; i++) begin
            m_inst[i] = '0; m_shift[i] = '0; m_key[i] = '0; m_peak[i] = '0;
            m_peak_lvl[i] = '0; m_steps[i] = '0; m_periods[i] = '0;
            m_sus[i] = '0; m_tick[i] = '0; m_level[i] = '0;
         end
      end else if (start && !busy) begin
         predict_command(req_item);
      end
   end

   // driver
   always @(negedge clock) begin
      if (reset) begin
         start <= 1'b0;
         req_item <= '0;
         gap <= 0;
         hold_until_drained <= 1'b0;
      end else if (start && !taken) begin
         // still waiting for acceptance
      end else if (gap > 0) begin
         gap <= gap - 1;
         start <= 1'b0;
      end else if (pending_cmds.size() > 0
                   && !(hold_until_drained && expected_rsp.size() > 0)) begin
         if (pending_cmds[0].operation === 3'd7 && pending_cmds[0].channel === 2'd3
             && pending_cmds[0].hw_channel === 8'hA5) begin
            // drain marker
            hold_until_drained <= 1'b1;
            void'(pending_cmds.pop_front());
            start <= 1'b0;
         end else begin
            hold_until_drained <= 1'b0;
            req_item <= pending_cmds.pop_front();
            start <= 1'b1;
            gap <= pick_gap();
         end
      end else begin
         start <= 1'b0;
      end
   end

   // monitor
   always @(posedge clock) begin
      psg_pkg::rsp_type want;
      if (!reset && rsp_strobe) begin
         if (expected_rsp.size() == 0) begin
            report_mismatch("unexpected result", rsp_item, 0);
         end else begin
            want = expected_rsp.pop_front();
            if (rsp_item.port_byte !== want.port_byte)
               report_mismatch("port_byte", rsp_item.port_byte, want.port_byte);
            if (rsp_item.byte_valid !== want.byte_valid)
               report_mismatch("byte_valid", rsp_item.byte_valid, want.byte_valid);
            if (rsp_item.channel_out !== want.channel_out)
               report_mismatch("channel_out", rsp_item.channel_out, want.channel_out);
            if (rsp_item.last !== want.last)
               report_mismatch("last", rsp_item.last, want.last);
         end
      end
   end

   always @(posedge clock) begin
      cycles <= cycles + 1;
      if (cycles > CYCLE_LIMIT) begin
         $display("psg_adsr_envelope_driver_test failed");
         $finish;
      end
   end

   task automatic queue_random(input int n);
      int r;
      for (int i = 0; i < n; i++) begin
         r = $urandom_range(0, 99);
         if (r < 15) queue_cmd(psg_pkg::OP_INSTRUMENT, 2'($urandom), 8'($urandom),
                               8'(($urandom_range(0, 9) == 0) ? $urandom
                                                               : $urandom_range(0, 23)));
         else if (r < 35) queue_cmd(psg_pkg::OP_NOTE_ON, 2'($urandom), 8'($urandom),
                                    8'(($urandom_range(0, 4) == 0) ? $urandom
                                                                    : $urandom_range(20, 90)));
         else if (r < 45) queue_cmd(psg_pkg::OP_NOTE_OFF, 2'($urandom), 8'($urandom),
                                    8'($urandom));
         else if (r < 88) queue_cmd(psg_pkg::OP_TICK, 2'($urandom), 8'($urandom),
                                    8'($urandom));
         else if (r < 92) queue_cmd(psg_pkg::OP_RELEASE_ALL, 2'($urandom), 8'($urandom),
                                    8'($urandom));
         else if (r < 95) queue_cmd(psg_pkg::OP_SILENCE, 2'($urandom), 8'($urandom),
                                    8'($urandom));
         else if (r < 98) queue_cmd(psg_pkg::OP_RESET, 2'($urandom), 8'($urandom),
                                    8'($urandom));
         else queue_cmd(3'd7, 2'($urandom_range(0, 2)), 8'($urandom), 8'($urandom));
      end
   endtask

   initial begin
      int waited;
      reset = 1'b1;
      // directed
      queue_cmd(psg_pkg::OP_RESET, 2'd0, 8'd0, 8'd0);
      queue_cmd(psg_pkg::OP_SILENCE, 2'd3, 8'hff, 8'hff);
      queue_cmd(psg_pkg::OP_NOTE_ON, 2'd0, 8'd0, 8'd0);
      queue_cmd(psg_pkg::OP_NOTE_ON, 2'd1, 8'd0, 8'd255);
      queue_cmd(psg_pkg::OP_NOTE_ON, 2'd2, 8'd0, 8'd83);
      queue_cmd(psg_pkg::OP_NOTE_ON, 2'd0, 8'd0, 8'd84);
      queue_cmd(psg_pkg::OP_INSTRUMENT, 2'd3, 8'd255, 8'd19);
      queue_cmd(psg_pkg::OP_INSTRUMENT, 2'd1, 8'd0, 8'd10);
      queue_cmd(psg_pkg::OP_NOTE_ON, 2'd3, 8'd0, 8'd40);
      queue_cmd(psg_pkg::OP_INSTRUMENT, 2'd2, 8'd0, 8'd6);
      queue_cmd(psg_pkg::OP_NOTE_ON, 2'd2, 8'd0, 8'd30);
      queue_cmd(psg_pkg::OP_INSTRUMENT, 2'd0, 8'd0, 8'd24);
      queue_cmd(psg_pkg::OP_INSTRUMENT, 2'd0, 8'd0, 8'd255);
      for (int i = 0; i < 6; i++) queue_cmd(psg_pkg::OP_TICK, 2'd0, 8'd0, 8'd0);
      queue_cmd(psg_pkg::OP_NOTE_OFF, 2'd2, 8'd0, 8'd0);
      queue_cmd(psg_pkg::OP_RELEASE_ALL, 2'd0, 8'd0, 8'd0);
      queue_cmd(3'd7, 2'd1, 8'd0, 8'd0);
      queue_cmd(3'd7, 2'd3, 8'hA5, 8'd0);
      queue_random(220);
      queue_cmd(3'd7, 2'd3, 8'hA5, 8'd0);
      queue_random(220);
      repeat (8) @(posedge clock);
      @(negedge clock) reset = 1'b0;
      wait (pending_cmds.size() == 0 && !start);
      waited = 0;
      while ((expected_rsp.size() != 0 || waited < 40) && waited < 2000) begin
         @(posedge clock);
         if (expected_rsp.size() == 0) waited++;
      end
      if (errors == 0 && expected_rsp.size() == 0) begin
         $display("psg_adsr_envelope_driver_test passed");
      end else begin
         $display("psg_adsr_envelope_driver_test failed");
      end
      $finish;
   end
endmodule
